>>> sv/ilt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ilt_pkg: shared types and constants for the IP lease table
// Table depth, derived index and count widths, command and status codes,
// item structs and the store request bundle.
// ----------------------------------------------------------------------------
package ilt_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int COUNT_W     = $clog2(TABLE_DEPTH + 1);

  localparam int CMD_W   = 3;
  localparam int STAT_W  = 2;
  localparam int ECOUNT_W = 7;

  localparam logic [CMD_W-1:0] CMD_ADD    = 3'd0;
  localparam logic [CMD_W-1:0] CMD_FIND   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_UPDATE = 3'd2;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd3;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd4;

  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL      = 2'd2;

  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic [31:0]      ip_address;
    logic [31:0]      lease_time;
  } cmd_item_t;

  typedef struct packed {
    logic [STAT_W-1:0]   status;
    logic [31:0]         found_lease_time;
    logic [ECOUNT_W-1:0] entry_count;
  } rsp_item_t;

  typedef struct packed {
    logic [31:0] addr;
    logic [31:0] lease;
  } entry_t;

  typedef struct packed {
    logic             rd_en;
    logic [IDX_W-1:0] rd_idx;
    logic             wr_en;
    logic [IDX_W-1:0] wr_idx;
    entry_t           wr_data;
  } mem_req_t;

endpackage

>>> sv/ilt_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ilt_store: entry memory
// One write port and one registered read port over address/lease entries.
// ----------------------------------------------------------------------------
module ilt_store
  import ilt_pkg::*;
(
  input  logic     clk,
  input  mem_req_t req,
  output entry_t   rd_data
);

  entry_t mem [TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_idx] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data <= mem[req.rd_idx];
    end
  end

endmodule

>>> sv/ilt_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ilt_ctrl: command sequencer
// Walks the table newest-first with one shared address compare, patches
// leases in place and shifts entries down on remove.
// ----------------------------------------------------------------------------
module ilt_ctrl
  import ilt_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      cmd_valid,
  output logic      cmd_stall,
  input  cmd_item_t cmd,
  output logic      res_valid,
  input  logic      res_ready,
  output rsp_item_t res,
  output mem_req_t  req,
  input  entry_t    rd_data
);

  typedef enum logic [1:0] {S_IDLE, S_SEARCH, S_SHIFT, S_DONE} state_t;

  state_t              state;
  logic [CMD_W-1:0]    op;
  logic [31:0]         key;
  logic [31:0]         lease;
  logic [COUNT_W-1:0]  count;
  logic [IDX_W-1:0]    idx;
  logic [STAT_W-1:0]   status;
  logic [31:0]         found;

  logic                match;
  logic                shift_last;
  logic                at_top;
  logic                full;
  logic [COUNT_W-1:0]  count_m1;

  assign match      = (rd_data.addr == key);
  assign count_m1   = count - COUNT_W'(1);
  assign shift_last = (COUNT_W'(idx) + COUNT_W'(2)) == count;
  assign at_top     = (COUNT_W'(idx) + COUNT_W'(1)) == count;
  assign full       = (count == COUNT_W'(TABLE_DEPTH));

  assign cmd_stall = (state != S_IDLE);
  assign res_valid = (state == S_DONE);
  assign res.status           = status;
  assign res.found_lease_time = found;
  assign res.entry_count      = ECOUNT_W'(count);

  always_comb begin
    req = '0;
    req.rd_idx = idx - IDX_W'(1);
    req.wr_idx = idx;
    req.wr_data = rd_data;
    unique case (state)
      S_IDLE: begin
        req.rd_en   = (count != '0);
        req.rd_idx  = count_m1[IDX_W-1:0];
        req.wr_en   = cmd_valid && (cmd.command == CMD_ADD) && !full;
        req.wr_idx  = count[IDX_W-1:0];
        req.wr_data = '{addr: cmd.ip_address, lease: cmd.lease_time};
      end
      S_SEARCH: begin
        req.rd_en = 1'b1;
        if (match && op == CMD_REMOVE) begin
          req.rd_idx = idx + IDX_W'(1);
        end
        req.wr_en   = match && (op == CMD_UPDATE);
        req.wr_data = '{addr: rd_data.addr, lease: lease};
      end
      S_SHIFT: begin
        req.wr_en  = 1'b1;
        req.rd_en  = !shift_last;
        req.rd_idx = idx + IDX_W'(2);
      end
      S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            op     <= cmd.command;
            key    <= cmd.ip_address;
            lease  <= cmd.lease_time;
            status <= ST_OK;
            found  <= '0;
            state  <= S_DONE;
            case (cmd.command) inside
              CMD_ADD: begin
                if (full) begin
                  status <= ST_FULL;
                end else begin
                  count <= count + COUNT_W'(1);
                end
              end
              CMD_FIND, CMD_UPDATE, CMD_REMOVE: begin
                if (count == '0) begin
                  status <= ST_NOT_FOUND;
                end else begin
                  idx   <= count_m1[IDX_W-1:0];
                  state <= S_SEARCH;
                end
              end
              CMD_CLEAR: begin
                count <= '0;
              end
              default: begin
              end
            endcase
          end
        end
        S_SEARCH: begin
          if (match) begin
            state <= S_DONE;
            case (op)
              CMD_FIND: found <= rd_data.lease;
              CMD_REMOVE: begin
                if (at_top) begin
                  count <= count_m1;
                end else begin
                  state <= S_SHIFT;
                end
              end
              default: begin
              end
            endcase
          end else if (idx == '0) begin
            status <= ST_NOT_FOUND;
            state  <= S_DONE;
          end else begin
            idx <= idx - IDX_W'(1);
          end
        end
        S_SHIFT: begin
          if (shift_last) begin
            count <= count_m1;
            state <= S_DONE;
          end else begin
            idx <= idx + IDX_W'(1);
          end
        end
        S_DONE: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= COUNT_W'(TABLE_DEPTH))
    else $error("entry count above table depth");

  a_write_in_range: assert property (@(posedge clk) disable iff (rst)
    req.wr_en |-> (COUNT_W'(req.wr_idx) < count) || (state == S_IDLE && !full))
    else $error("write beyond live entries");

  a_add_grows: assert property (@(posedge clk) disable iff (rst)
    (cmd_valid && !cmd_stall && cmd.command == CMD_ADD && !full)
    |=> count == COUNT_W'($past(count) + COUNT_W'(1)))
    else $error("add did not grow the table");

  a_shift_below_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_SHIFT) |-> (COUNT_W'(idx) + COUNT_W'(2)) <= count)
    else $error("shift past last entry");
`endif

endmodule

>>> sv/ip_lease_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ip_lease_table: bounded IPv4 address / lease table
// Add, find, update, remove and clear over a TABLE_DEPTH entry store.
// ----------------------------------------------------------------------------
// Each command item is taken while the sequencer is idle and yields one
// response item through an output register, so a new command can be taken
// while the last response still waits. Add, clear and unused codes answer
// without a walk. Find and update walk the store newest-first, one entry
// per cycle through the single read port and address compare, stopping at
// the first match or after the oldest entry. Remove then moves each later
// entry down one slot through the same port.
module ip_lease_table
  import ilt_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      cmd_valid,
  output logic      cmd_stall,
  input  cmd_item_t cmd,
  output logic      rsp_valid,
  input  logic      rsp_stall,
  output rsp_item_t rsp
);

  mem_req_t  req;
  entry_t    rd_data;
  logic      res_valid;
  logic      res_ready;
  rsp_item_t res;

  assign res_ready = !rsp_valid || !rsp_stall;

  ilt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .req       (req),
    .rd_data   (rd_data)
  );

  ilt_store u_store (
    .clk     (clk),
    .req     (req),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (res_ready) begin
      rsp_valid <= res_valid;
      if (res_valid) begin
        rsp <= res;
      end
    end
  end

endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the IP lease table
// Drives command items through the valid/stall handshake with random gaps,
// stalls the response side at random, and checks every response against
// a cycle-free predictor of the table. It covers directed corner cases, a
// fill to capacity, and long random mixes over small address pools.
// ----------------------------------------------------------------------------
module testbench;
  import ilt_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int TAIL_CYCLES = 2 * TABLE_DEPTH + 8;
  localparam int POOL_SIZE   = 24;
  localparam int MAX_REPORTS = 40;

  localparam logic [CMD_W-1:0] CMD_UNUSED_FIRST = CMD_CLEAR + 1'b1;
  localparam logic [CMD_W-1:0] CMD_UNUSED_LAST  = '1;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      cmd_valid = 1'b0;
  logic      cmd_stall;
  cmd_item_t cmd = '0;
  logic      rsp_valid;
  logic      rsp_stall = 1'b0;
  rsp_item_t rsp;

  ip_lease_table dut (
    .clk      (clk),
    .rst      (rst),
    .cmd_valid(cmd_valid),
    .cmd_stall(cmd_stall),
    .cmd      (cmd),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp      (rsp)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // predicted table contents, newest entry in the highest slot
  logic [31:0] held_addr [TABLE_DEPTH];
  logic [31:0] held_lease[TABLE_DEPTH];
  int          held_count = 0;

  rsp_item_t   pending_results[$];
  logic [31:0] addr_pool[POOL_SIZE];
  int          pool_used = POOL_SIZE;
  bit          quiet = 1'b0;
  int          rsp_hold = 0;
  int          error_count = 0;
  int          cycle_count = 0;

  function automatic rsp_item_t predict_lease_result(cmd_item_t c);
    rsp_item_t r;
    int        hit;
    r   = '0;
    hit = -1;
    for (int i = held_count - 1; i >= 0; i--) begin
      if (hit < 0 && held_addr[i] == c.ip_address) hit = i;
    end
    r.status = ST_OK;
    case (c.command)
      CMD_ADD: begin
        if (held_count >= TABLE_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          held_addr[held_count]  = c.ip_address;
          held_lease[held_count] = c.lease_time;
          held_count++;
        end
      end
      CMD_FIND: begin
        if (hit < 0) r.status = ST_NOT_FOUND;
        else r.found_lease_time = held_lease[hit];
      end
      CMD_UPDATE: begin
        if (hit < 0) r.status = ST_NOT_FOUND;
        else held_lease[hit] = c.lease_time;
      end
      CMD_REMOVE: begin
        if (hit < 0) begin
          r.status = ST_NOT_FOUND;
        end else begin
          for (int i = hit; i < held_count - 1; i++) begin
            held_addr[i]  = held_addr[i + 1];
            held_lease[i] = held_lease[i + 1];
          end
          held_count--;
        end
      end
      CMD_CLEAR: held_count = 0;
      default: ;
    endcase
    r.entry_count = ECOUNT_W'(held_count);
    return r;
  endfunction

  function automatic cmd_item_t cmd_of(logic [CMD_W-1:0] op, logic [31:0] a, logic [31:0] l);
    cmd_item_t c;
    c.command    = op;
    c.ip_address = a;
    c.lease_time = l;
    return c;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    if (error_count < MAX_REPORTS)
      $display("MISMATCH %s: got %h expected %h at cycle %0d", what, got, want, cycle_count);
    error_count++;
  endtask

  // sends one item; valid stays high when the next item follows without a gap
  task automatic send_item(cmd_item_t c);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      @(negedge clk);
      cmd_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    cmd_valid <= 1'b1;
    cmd       <= c;
    do @(posedge clk); while (cmd_stall);
    pending_results.push_back(predict_lease_result(c));
  endtask

  task automatic wait_drained();
    @(negedge clk);
    cmd_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // response side: random stall after every accepted item, then compare
  always @(negedge clk) begin
    if (rsp_hold > 0) begin
      rsp_stall <= 1'b1;
      rsp_hold  <= rsp_hold - 1;
    end else begin
      rsp_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    rsp_item_t want;
    cycle_count <= cycle_count + 1;
    if (!rst && rsp_valid && !rsp_stall) begin
      rsp_hold = quiet ? 0 : $urandom_range(0, 3);
      if (pending_results.size() == 0) begin
        report_mismatch("response with no command pending", rsp.found_lease_time, '0);
      end else begin
        want = pending_results.pop_front();
        if (rsp.status !== want.status)
          report_mismatch("status", 32'(rsp.status), 32'(want.status));
        if (rsp.found_lease_time !== want.found_lease_time)
          report_mismatch("found_lease_time", rsp.found_lease_time, want.found_lease_time);
        if (rsp.entry_count !== want.entry_count)
          report_mismatch("entry_count", 32'(rsp.entry_count), 32'(want.entry_count));
      end
    end
  end

  initial begin : watchdog
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Verification failed");
    $finish;
  end

  function automatic logic [31:0] draw_lease();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return $urandom();
  endfunction

  function automatic logic [31:0] draw_addr();
    int r;
    r = $urandom_range(0, 99);
    if (r < 85) return addr_pool[$urandom_range(0, pool_used - 1)];
    if (r < 87) return '0;
    if (r < 89) return '1;
    return $urandom();
  endfunction

  task automatic refill_pool(int n);
    pool_used = n;
    foreach (addr_pool[i]) addr_pool[i] = $urandom();
  endtask

  task automatic test_directed();
    send_item(cmd_of(CMD_CLEAR,  32'h0,        32'h0));
    send_item(cmd_of(CMD_FIND,   32'h0,        32'h0));
    send_item(cmd_of(CMD_UPDATE, 32'hFFFFFFFF, 32'h5));
    send_item(cmd_of(CMD_REMOVE, 32'h0,        32'h0));
    send_item(cmd_of(CMD_ADD,    32'h0,        32'hFFFFFFFF));
    send_item(cmd_of(CMD_ADD,    32'hFFFFFFFF, 32'h0));
    send_item(cmd_of(CMD_ADD,    32'h0A000001, 32'd3600));
    send_item(cmd_of(CMD_ADD,    32'h0A000001, 32'd7200));
    send_item(cmd_of(CMD_FIND,   32'h0A000001, 32'h0));
    send_item(cmd_of(CMD_UPDATE, 32'h0A000001, 32'd1));
    send_item(cmd_of(CMD_FIND,   32'h0,        32'h0));
    send_item(cmd_of(CMD_FIND,   32'hFFFFFFFF, 32'hFFFFFFFF));
    send_item(cmd_of(CMD_REMOVE, 32'h0A000001, 32'h0));
    send_item(cmd_of(CMD_FIND,   32'h0A000001, 32'h0));
    send_item(cmd_of(CMD_REMOVE, 32'h0,        32'h0));
    send_item(cmd_of(CMD_FIND,   32'hFFFFFFFF, 32'h0));
    send_item(cmd_of(CMD_FIND,   32'h0A000002, 32'h0));
    send_item(cmd_of(CMD_UNUSED_FIRST,        $urandom(), $urandom()));
    send_item(cmd_of(CMD_UNUSED_FIRST + 1'b1, $urandom(), $urandom()));
    send_item(cmd_of(CMD_UNUSED_LAST,         32'hFFFFFFFF, 32'hFFFFFFFF));
    send_item(cmd_of(CMD_CLEAR,  32'hFFFFFFFF, 32'hFFFFFFFF));
    send_item(cmd_of(CMD_FIND,   32'hFFFFFFFF, 32'h0));
  endtask

  // fill to capacity, overflow, then deep lookups and the longest shift
  task automatic test_full_table();
    logic [31:0] oldest;
    oldest = $urandom();
    refill_pool(POOL_SIZE);
    send_item(cmd_of(CMD_ADD, oldest, draw_lease()));
    for (int i = 1; i < TABLE_DEPTH; i++) send_item(cmd_of(CMD_ADD, draw_addr(), draw_lease()));
    send_item(cmd_of(CMD_ADD, $urandom(), draw_lease()));
    send_item(cmd_of(CMD_ADD, oldest, draw_lease()));
    send_item(cmd_of(CMD_FIND, oldest, 32'h0));
    send_item(cmd_of(CMD_FIND, $urandom(), 32'h0));
    send_item(cmd_of(CMD_UPDATE, oldest, draw_lease()));
    send_item(cmd_of(CMD_REMOVE, oldest, 32'h0));
    send_item(cmd_of(CMD_ADD, oldest, draw_lease()));
    send_item(cmd_of(CMD_FIND, oldest, 32'h0));
    send_item(cmd_of(CMD_CLEAR, 32'h0, 32'h0));
  endtask

  task automatic random_burst(int n, int add_pct);
    int          r;
    logic [CMD_W-1:0] op;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      if (r < add_pct) op = CMD_ADD;
      else if (r < add_pct + 2) op = CMD_CLEAR;
      else if (r < add_pct + 5) op = CMD_CLEAR + CMD_W'($urandom_range(1, 3));
      else begin
        case ($urandom_range(0, 2))
          0: op = CMD_FIND;
          1: op = CMD_UPDATE;
          default: op = CMD_REMOVE;
        endcase
      end
      send_item(cmd_of(op, draw_addr(), draw_lease()));
    end
  endtask

  task automatic test_random_mix();
    refill_pool(POOL_SIZE);
    quiet = 1'b0;
    random_burst(250, 60);
    wait_drained();
    random_burst(200, 20);
    quiet = 1'b1;
    random_burst(150, 45);
    wait_drained();
    quiet = 1'b0;
    refill_pool(8);
    random_burst(300, 50);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    wait_drained();
    test_full_table();
    wait_drained();
    test_random_mix();
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
